/* design/bgd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the bigram text decoder.
// No dependencies; imported by the front end, back end and top level.
package bgd_pkg;

    localparam int CAPACITY_WIDTH_DEF = 16;
    localparam int CAP_IN_W           = 16;
    localparam int BYTE_W             = 8;
    localparam int IDX_W              = 7;
    localparam int PAIR_W             = 2 * BYTE_W;
    localparam int TABLE_DEPTH        = 128;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_DATA  = 2'd2,
        MODE_RSVD  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_CHAR  = 2'd1,
        K_PAIR  = 2'd2,
        K_END   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

endpackage

/* design/bgd_queue.sv */
`timescale 1ns / 1ps
// Small register queue that holds classified commands between front and back.
// Depends on nothing beyond its parameters.
module bgd_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* design/bgd_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input items, keeps the pair table and classifies each item.
// Depends on bgd_pkg.
module bgd_front #(
    parameter int CAPACITY_WIDTH = bgd_pkg::CAPACITY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [1:0]                    i_mode,
    input  logic [bgd_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [bgd_pkg::BYTE_W-1:0]    i_pair_first,
    input  logic [bgd_pkg::BYTE_W-1:0]    i_pair_second,
    input  logic [bgd_pkg::CAP_IN_W-1:0]  i_capacity,
    input  logic [bgd_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          o_cmd_valid,
    output bgd_pkg::t_cmd                 o_cmd,
    output logic [CAPACITY_WIDTH-1:0]     o_cmd_cap,
    input  logic                          i_cmd_full
);
    import bgd_pkg::*;

    logic [PAIR_W-1:0]              r_table [TABLE_DEPTH];
    logic [PAIR_W-1:0]              r_rd;
    logic                           r_s1_valid, n_s1_valid;
    logic                           r_s1_start;
    logic [BYTE_W-1:0]              r_s1_byte;
    logic [CAPACITY_WIDTH-1:0]      r_s1_cap;
    logic [CAP_IN_W+CAPACITY_WIDTH-1:0] cap_ext;
    logic                           accept;
    logic                           advance;
    logic                           is_load;
    logic                           is_work;

    assign o_full  = r_s1_valid && i_cmd_full;
    assign accept  = i_push && !o_full;
    assign advance = r_s1_valid && !i_cmd_full;
    assign is_load = (t_mode'(i_mode) == MODE_LOAD);
    assign is_work = (t_mode'(i_mode) == MODE_START) || (t_mode'(i_mode) == MODE_DATA);
    assign cap_ext = {{CAPACITY_WIDTH{1'b0}}, i_capacity};

    always_ff @(posedge i_clk) begin
        if (accept && is_load) begin
            r_table[i_entry_index] <= {i_pair_first, i_pair_second};
        end
        if (accept) begin
            r_rd <= r_table[i_data_byte[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_work) begin
            r_s1_start <= (t_mode'(i_mode) == MODE_START);
            r_s1_byte  <= i_data_byte;
            r_s1_cap   <= cap_ext[CAPACITY_WIDTH-1:0];
        end
    end

    always_comb begin
        if (accept && is_work) begin
            n_s1_valid = 1'b1;
        end else if (advance) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_comb begin
        o_cmd.first  = r_s1_byte;
        o_cmd.second = r_rd[BYTE_W-1:0];
        if (r_s1_start) begin
            o_cmd.kind = K_START;
        end else if (r_s1_byte == TERMINATOR) begin
            o_cmd.kind = K_END;
        end else if (r_s1_byte[BYTE_W-1] && (r_rd[PAIR_W-1:BYTE_W] != TERMINATOR)) begin
            o_cmd.kind  = K_PAIR;
            o_cmd.first = r_rd[PAIR_W-1:BYTE_W];
        end else begin
            o_cmd.kind = K_CHAR;
        end
    end

    assign o_cmd_valid = advance;
    assign o_cmd_cap   = r_s1_cap;

endmodule

/* design/bgd_back.sv */
`timescale 1ns / 1ps
// Back end: tracks the open string, emits a character per cycle unless stalled.
// Depends on bgd_pkg.
module bgd_back #(
    parameter int CAPACITY_WIDTH = bgd_pkg::CAPACITY_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_empty,
    input  bgd_pkg::t_cmd               i_cmd,
    input  logic [CAPACITY_WIDTH-1:0]   i_cmd_cap,
    output logic                        o_cmd_pop,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [bgd_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_last
);
    import bgd_pkg::*;

    logic [CAPACITY_WIDTH-1:0] r_slots, n_slots;
    logic                      r_done, n_done;
    logic                      r_pend2, n_pend2;
    logic                      r_pend_t, n_pend_t;
    logic [BYTE_W-1:0]         r_second;
    logic                      r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]         r_out_byte;
    logic                      r_out_last;
    logic                      out_take;
    logic                      out_free;
    logic                      emit;
    logic [BYTE_W-1:0]         e_byte;
    logic                      e_last;

    assign out_take = r_out_valid && i_pop;
    assign out_free = !r_out_valid || out_take;

    always_comb begin
        logic [CAPACITY_WIDTH-1:0] s1;
        logic [CAPACITY_WIDTH-1:0] s2;
        s1        = r_slots - 1'b1;
        s2        = r_slots - 2'd2;
        n_slots   = r_slots;
        n_done    = r_done;
        n_pend2   = r_pend2;
        n_pend_t  = r_pend_t;
        o_cmd_pop = 1'b0;
        emit      = 1'b0;
        e_byte    = TERMINATOR;
        e_last    = 1'b0;
        if (r_pend2) begin
            if (out_free) begin
                emit    = 1'b1;
                e_byte  = r_second;
                n_pend2 = 1'b0;
            end
        end else if (r_pend_t) begin
            if (out_free) begin
                emit     = 1'b1;
                e_last   = 1'b1;
                n_pend_t = 1'b0;
            end
        end else if (!i_cmd_empty) begin
            case (i_cmd.kind)
                K_START: begin
                    if (i_cmd_cap[CAPACITY_WIDTH-1:1] != '0) begin
                        o_cmd_pop = 1'b1;
                        n_slots   = i_cmd_cap;
                        n_done    = 1'b0;
                    end else if (out_free) begin
                        o_cmd_pop = 1'b1;
                        n_slots   = i_cmd_cap;
                        n_done    = 1'b1;
                        emit      = 1'b1;
                        e_last    = 1'b1;
                    end
                end
                K_END: begin
                    if (r_done) begin
                        o_cmd_pop = 1'b1;
                    end else if (out_free) begin
                        o_cmd_pop = 1'b1;
                        n_done    = 1'b1;
                        emit      = 1'b1;
                        e_last    = 1'b1;
                    end
                end
                K_PAIR: begin
                    if (r_done) begin
                        o_cmd_pop = 1'b1;
                    end else if (out_free) begin
                        o_cmd_pop = 1'b1;
                        emit      = 1'b1;
                        e_byte    = i_cmd.first;
                        if (s1[CAPACITY_WIDTH-1:1] != '0) begin
                            n_pend2 = 1'b1;
                            n_slots = s2;
                            if (s2[CAPACITY_WIDTH-1:1] == '0) begin
                                n_pend_t = 1'b1;
                                n_done   = 1'b1;
                            end
                        end else begin
                            n_slots  = s1;
                            n_pend_t = 1'b1;
                            n_done   = 1'b1;
                        end
                    end
                end
                default: begin
                    if (r_done) begin
                        o_cmd_pop = 1'b1;
                    end else if (out_free) begin
                        o_cmd_pop = 1'b1;
                        emit      = 1'b1;
                        e_byte    = i_cmd.first;
                        n_slots   = s1;
                        if (s1[CAPACITY_WIDTH-1:1] == '0) begin
                            n_pend_t = 1'b1;
                            n_done   = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= e_byte;
            r_out_last <= e_last;
        end
        if (o_cmd_pop && (i_cmd.kind == K_PAIR)) begin
            r_second <= i_cmd.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots     <= '0;
            r_done      <= 1'b1;
            r_pend2     <= 1'b0;
            r_pend_t    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_slots     <= n_slots;
            r_done      <= n_done;
            r_pend2     <= n_pend2;
            r_pend_t    <= n_pend_t;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

/* design/bigram_text_decoder.sv */
`timescale 1ns / 1ps
// Top level of the bigram text decoder: front end, command queue and back end.
// Depends on bgd_pkg, bgd_front, bgd_queue and bgd_back.
//
// Input items are offered with push and taken when full is low. An item
// loads a pair table entry, opens a string with a capacity, or carries one
// compressed data byte. Results are read like a queue: while empty is low
// the oldest character is on o_out_byte and o_last, and pop takes it.
// The front end takes one item per cycle while full is low and reads the pair
// table in a registered read, so an accepted item is held in the front stage
// register before it is pushed into the command queue. Its first character
// then passes through the command queue into the output register. The back
// end emits one character per cycle while the output register is free, so a
// data byte that expands to a pair keeps it busy until both are emitted.
// When the receiver stalls, the output register, the four-entry command queue
// and the front stage register fill, and full then rises. Reset empties all
// queues and leaves no string open; data bytes are ignored until a start item.
// The pair table is not cleared and must be loaded before its entries are used.
module bigram_text_decoder #(
    parameter int CAPACITY_WIDTH = bgd_pkg::CAPACITY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_mode,
    input  logic [bgd_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [bgd_pkg::BYTE_W-1:0]    i_pair_first,
    input  logic [bgd_pkg::BYTE_W-1:0]    i_pair_second,
    input  logic [bgd_pkg::CAP_IN_W-1:0]  i_capacity,
    input  logic [bgd_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [bgd_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_last
);
    import bgd_pkg::*;

    localparam int Q_W = CMD_W + CAPACITY_WIDTH;

    logic                      f_cmd_valid;
    t_cmd                      f_cmd;
    logic [CAPACITY_WIDTH-1:0] f_cmd_cap;
    logic                      q_full;
    logic                      q_empty;
    logic                      q_pop;
    logic [Q_W-1:0]            q_head;
    t_cmd                      b_cmd;
    logic [CAPACITY_WIDTH-1:0] b_cmd_cap;

    bgd_front #(
        .CAPACITY_WIDTH (CAPACITY_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_mode        (i_mode),
        .i_entry_index (i_entry_index),
        .i_pair_first  (i_pair_first),
        .i_pair_second (i_pair_second),
        .i_capacity    (i_capacity),
        .i_data_byte   (i_data_byte),
        .o_cmd_valid   (f_cmd_valid),
        .o_cmd         (f_cmd),
        .o_cmd_cap     (f_cmd_cap),
        .i_cmd_full    (q_full)
    );

    bgd_queue #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_cmd_valid),
        .i_data  ({f_cmd, f_cmd_cap}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_empty (q_empty)
    );

    assign b_cmd     = t_cmd'(q_head[Q_W-1:CAPACITY_WIDTH]);
    assign b_cmd_cap = q_head[CAPACITY_WIDTH-1:0];

    bgd_back #(
        .CAPACITY_WIDTH (CAPACITY_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd       (b_cmd),
        .i_cmd_cap   (b_cmd_cap),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bigram_text_decoder: a scoreboard class predicts every
// decoded character from each accepted item and checks the output queue in order.
// Depends on bgd_pkg and bigram_text_decoder.
module tb;
    import bgd_pkg::*;

    localparam int CAP_W       = CAPACITY_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } t_out_char;

    class char_scoreboard;
        logic [PAIR_W-1:0] pair_table [TABLE_DEPTH];
        logic [CAP_W-1:0]  slots_left;
        bit                string_done;
        t_out_char         expected_chars[$];
        int                failures;

        function new();
            foreach (pair_table[i]) pair_table[i] = '0;
            slots_left  = '0;
            string_done = 1'b1;
            failures    = 0;
        endfunction

        function void expect_char(logic [BYTE_W-1:0] ch, logic last);
            t_out_char c;
            c.ch   = ch;
            c.last = last;
            expected_chars.push_back(c);
            if (last) begin
                string_done = 1'b1;
            end
        endfunction

        function void note_item(t_mode mode, logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] first,
                                logic [BYTE_W-1:0] second, logic [CAP_IN_W-1:0] cap,
                                logic [BYTE_W-1:0] data);
            logic [PAIR_W-1:0] entry;
            entry = '0;
            case (mode)
                MODE_LOAD: begin
                    pair_table[idx] = {first, second};
                end
                MODE_START: begin
                    slots_left  = cap[CAP_W-1:0];
                    string_done = 1'b0;
                    if (slots_left <= 1) begin
                        expect_char(TERMINATOR, 1'b1);
                    end
                end
                MODE_DATA: begin
                    if (!string_done) begin
                        if (data == TERMINATOR) begin
                            expect_char(TERMINATOR, 1'b1);
                        end else begin
                            if (data[BYTE_W-1]) begin
                                entry = pair_table[data[IDX_W-1:0]];
                            end
                            if (entry[PAIR_W-1:BYTE_W] != '0) begin
                                expect_char(entry[PAIR_W-1:BYTE_W], 1'b0);
                                slots_left--;
                                if (slots_left > 1) begin
                                    expect_char(entry[BYTE_W-1:0], 1'b0);
                                    slots_left--;
                                end
                            end else begin
                                expect_char(data, 1'b0);
                                slots_left--;
                            end
                            if (slots_left <= 1) begin
                                expect_char(TERMINATOR, 1'b1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void check_char(logic [BYTE_W-1:0] ch, logic last);
            t_out_char want;
            if (expected_chars.size() == 0) begin
                report($sformatf("Unexpected character: out_byte=%02h last=%0b", ch, last));
            end else begin
                want = expected_chars.pop_front();
                if (want.ch !== ch) begin
                    report($sformatf("out_byte mismatch: expected %02h, got %02h", want.ch, ch));
                end
                if (want.last !== last) begin
                    report($sformatf("last mismatch: expected %0b, got %0b", want.last, last));
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [1:0]            i_mode;
    logic [IDX_W-1:0]      i_entry_index;
    logic [BYTE_W-1:0]     i_pair_first;
    logic [BYTE_W-1:0]     i_pair_second;
    logic [CAP_IN_W-1:0]   i_capacity;
    logic [BYTE_W-1:0]     i_data_byte;
    logic                  empty;
    logic                  pop;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_last;

    char_scoreboard        sb;
    int                    cycles;
    int                    burst_left;
    int                    pop_style;
    int                    phase_left;
    int                    stall_left;
    bit                    loaded [TABLE_DEPTH];
    logic [IDX_W-1:0]      loaded_idx[$];

    bigram_text_decoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_mode       (i_mode),
        .i_entry_index(i_entry_index),
        .i_pair_first (i_pair_first),
        .i_pair_second(i_pair_second),
        .i_capacity   (i_capacity),
        .i_data_byte  (i_data_byte),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                sb.note_item(t_mode'(i_mode), i_entry_index, i_pair_first, i_pair_second,
                             i_capacity, i_data_byte);
            end
            if (pop && !empty) begin
                sb.check_char(o_out_byte, o_last);
            end
        end
    end

    always @(negedge i_clk) begin
        if (phase_left == 0) begin
            pop_style  = $urandom_range(0, 3);
            phase_left = $urandom_range(20, 80);
        end
        phase_left--;
        case (pop_style)
            0: pop = 1'b1;
            1: pop = 1'($urandom_range(0, 1));
            2: pop = ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left > 0) begin
                    pop = 1'b0;
                    stall_left--;
                end else begin
                    pop = 1'b1;
                    if ($urandom_range(0, 5) == 0) begin
                        stall_left = $urandom_range(1, 8);
                    end
                end
            end
        endcase
    end

    function automatic logic [BYTE_W-1:0] pair_code();
        return {1'b1, loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]};
    endfunction

    // Filler for fields the item does not use; never points at an unloaded entry.
    function automatic logic [BYTE_W-1:0] safe_byte();
        if (loaded_idx.size() > 0 && $urandom_range(0, 1) == 1) begin
            return pair_code();
        end
        return BYTE_W'($urandom_range(0, 127));
    endfunction

    task automatic send_item(input t_mode mode, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
                             input logic [CAP_IN_W-1:0] cap, input logic [BYTE_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_mode        = mode;
        i_entry_index = idx;
        i_pair_first  = first;
        i_pair_second = second;
        i_capacity    = cap;
        i_data_byte   = data;
        push          = 1'b1;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] first,
                              input logic [BYTE_W-1:0] second);
        if (!loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_idx.push_back(idx);
        end
        send_item(MODE_LOAD, idx, first, second, CAP_IN_W'($urandom), safe_byte());
    endtask

    task automatic start_string(input logic [CAP_IN_W-1:0] cap);
        send_item(MODE_START, IDX_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), cap,
                  safe_byte());
    endtask

    task automatic data_in(input logic [BYTE_W-1:0] data);
        send_item(MODE_DATA, IDX_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  CAP_IN_W'($urandom), data);
    endtask

    task automatic reserved_item();
        send_item(MODE_RSVD, IDX_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  CAP_IN_W'($urandom), safe_byte());
    endtask

    task automatic drain();
        push = 1'b0;
        while (sb.expected_chars.size() != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic random_load();
        load_entry(IDX_W'($urandom), ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom),
                   BYTE_W'($urandom));
    endtask

    function automatic logic [CAP_IN_W-1:0] pick_capacity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return CAP_IN_W'($urandom_range(0, 12));
        end else if (r < 85) begin
            return CAP_IN_W'($urandom_range(13, 400));
        end
        return CAP_IN_W'($urandom);
    endfunction

    initial begin
        int  items;
        int  r;
        int  n;
        bit  paused;
        sb            = new();
        cycles        = 0;
        burst_left    = 0;
        pop_style     = 0;
        phase_left    = 0;
        stall_left    = 0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        i_mode        = MODE_LOAD;
        i_entry_index = '0;
        i_pair_first  = '0;
        i_pair_second = '0;
        i_capacity    = '0;
        i_data_byte   = '0;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        data_in(8'h41);
        reserved_item();
        load_entry(7'd0, "t", "h");
        load_entry(7'd127, 8'hff, 8'h01);
        load_entry(7'd5, 8'h00, "x");
        load_entry(7'd64, 8'h80, 8'h00);
        load_entry(7'd1, "e", " ");
        start_string(16'd0);
        start_string(16'd1);
        start_string(16'hffff);
        data_in(8'h7f);
        data_in(8'h80);
        data_in(8'hff);
        data_in(8'h85);
        data_in(8'hc0);
        data_in(TERMINATOR);
        start_string(16'd2);
        data_in(8'h80);
        data_in(8'h41);
        start_string(16'd10);
        data_in("a");
        start_string(16'd4);
        data_in(8'h81);
        load_entry(7'd1, "o", "n");
        start_string(16'd20);
        data_in(8'h81);
        data_in(TERMINATOR);
        drain();

        items  = 0;
        paused = 1'b0;
        while (items < 85) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                random_load();
                items++;
            end else if (r < 14) begin
                reserved_item();
            end else if (r < 18) begin
                data_in(BYTE_W'($urandom_range(0, 127)));
            end else begin
                start_string(pick_capacity());
                items++;
                n = $urandom_range(0, 12);
                repeat (n) begin
                    r = $urandom_range(0, 99);
                    if (r < 5) begin
                        random_load();
                    end else if (r < 50) begin
                        data_in(pair_code());
                    end else begin
                        data_in(BYTE_W'($urandom_range(1, 127)));
                    end
                    items++;
                end
                if ($urandom_range(0, 1) == 1) begin
                    data_in(TERMINATOR);
                    items++;
                end
            end
            if (items >= 40 && !paused) begin
                drain();
                paused = 1'b1;
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (sb.failures == 0 && sb.expected_chars.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
